/* src/sfp_pkg.sv */
`default_nettype none

package sfp_pkg;

   // Largest payload the block can ever accept, independent of the max_length register.
   localparam int MAX_PAYLOAD = 64;
   localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);

   // Framing bytes.
   localparam logic [7:0] HDR_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE = 8'h7D;
   localparam logic [7:0] ESC_HDR  = 8'h5E;
   localparam logic [7:0] ESC_ESC  = 8'h5D;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Parser phase codes.
   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_TYPE = 3'd1;
   localparam logic [2:0] PH_LEN0 = 3'd2;
   localparam logic [2:0] PH_LEN1 = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CRC0 = 3'd5;
   localparam logic [2:0] PH_CRC1 = 3'd6;

   // Result kind codes.
   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_GOOD    = 3'd1;
   localparam logic [2:0] KIND_CRCBAD  = 3'd2;
   localparam logic [2:0] KIND_TYPEBAD = 3'd3;
   localparam logic [2:0] KIND_ESCBAD  = 3'd4;
   localparam logic [2:0] KIND_LENBAD  = 3'd5;
   localparam logic [2:0] KIND_ABORT   = 3'd6;

   // Configuration register indexes.
   localparam logic REG_TYPE_LIMIT = 1'b0;
   localparam logic REG_MAX_LENGTH = 1'b1;

   // One result item plus its presence flag.
   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic [5:0]  byte_index;
      logic        last_byte;
      logic [7:0]  frame_kind;
      logic [15:0] computed_crc;
   } result_type;

   // Entry of the MSB-first CRC lookup for polynomial 0x1021.
   function automatic logic [15:0] crc16_lut(input logic [7:0] idx);
      logic [15:0] c;
      c = {idx, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/stuffed_frame_parser_crc16_top.sv */
`default_nettype none

// Channel  Direction  Transfer moves
// req      in         tdata[7:0] rx_byte
// rsp      out        tuser[2:0] kind, tlast last_byte, tdata payload/index/type/crc
// csr      in         csr_index selects type_limit (0) or max_length (1), csr_wdata value
//
// Each byte waits in the input register and is decided in one pass by the
// parser; its result, if any, lands in the output register as the byte moves on.
// One byte per cycle is sustained while rsp is not stalled; rsp valid is registered.
// Reset is synchronous and returns the parser to hunting, with type_limit 8, max_length 64.
// A stalled rsp holds its result while one more byte waits in the input register.
module stuffed_frame_parser_crc16_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Byte input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   // Result output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [7:0] payload_byte, [13:8] byte_index,
                                          // [21:14] frame_kind, [37:22] computed_crc
   output logic [2:0]       rsp_tuser,    // [2:0] kind
   output logic             rsp_tlast,    // last_byte
   // Configuration writes
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0]           type_limit_ff;
   logic [6:0]           max_length_ff;
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 advance;
   sfp_pkg::result_type  step_result;
   sfp_pkg::result_type  out_ff;
   logic                 out_valid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         type_limit_ff <= 8'd8;
         max_length_ff <= 7'd64;
      end else if (csr_we) begin
         if (csr_index == sfp_pkg::REG_TYPE_LIMIT) begin
            type_limit_ff <= csr_wdata;
         end else begin
            max_length_ff <= csr_wdata[6:0];
         end
      end
   end

   // The held byte moves on when the output register is free or drains this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   sfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .rx_byte    (in_byte_ff),
      .type_limit (type_limit_ff),
      .max_length (max_length_ff),
      .result     (step_result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_result.valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.valid) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last_byte;
   assign rsp_tdata  = {2'b00, out_ff.computed_crc, out_ff.frame_kind,
                        out_ff.byte_index, out_ff.payload_byte};

   // A held input byte is not overwritten while it waits.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a waiting byte");

   // Only payload bytes may carry the last-byte mark.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.last_byte |-> out_ff.kind == sfp_pkg::KIND_DATA)
      else $error("last-byte mark on a verdict");

   // Type and length rejections carry no CRC.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.kind == sfp_pkg::KIND_TYPEBAD
                       || out_ff.kind == sfp_pkg::KIND_LENBAD)
      |-> out_ff.computed_crc == 16'd0)
      else $error("header rejection with nonzero CRC");

   // A stalled result is not replaced by a new one.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !advance)
      else $error("parser stepped while result was stalled");

endmodule

`default_nettype wire

/* src/sfp_parser.sv */
`default_nettype none

// Frame parser state and the decision logic for one received byte.
module sfp_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [7:0]         type_limit,
   input  wire logic [6:0]         max_length,
   output sfp_pkg::result_type     result
);

   logic [2:0]  phase_ff,      phase_in;
   logic        esc_ff,        esc_in;
   logic [7:0]  len_hi_ff,     len_hi_in;
   logic [6:0]  dlen_ff,       dlen_in;
   logic [6:0]  count_ff,      count_in;
   logic [15:0] crc_ff,        crc_in;
   logic [7:0]  crc_hi_ff,     crc_hi_in;
   logic [7:0]  cur_type_ff,   cur_type_in;

   logic [7:0]  ubyte;
   logic [15:0] len_full;
   logic [15:0] limit;
   logic [15:0] crc_next;
   logic [6:0]  count_next;
   logic        is_last;

   // The length limit is the smaller of the register and the build-time maximum.
   assign limit = ({9'd0, max_length} < sfp_pkg::MAX_PAYLOAD_W) ? {9'd0, max_length}
                                                                : sfp_pkg::MAX_PAYLOAD_W;
   assign len_full   = {len_hi_ff, ubyte};
   assign crc_next   = {8'h00, crc_ff[15:8]} ^ sfp_pkg::crc16_lut(crc_ff[7:0] ^ ubyte);
   assign count_next = count_ff + 7'd1;
   assign is_last    = (count_next == dlen_ff);

   // Unescaped value of the byte when an escape is pending.
   always_comb begin
      if (esc_ff && rx_byte == sfp_pkg::ESC_HDR) begin
         ubyte = sfp_pkg::HDR_BYTE;
      end else if (esc_ff && rx_byte == sfp_pkg::ESC_ESC) begin
         ubyte = sfp_pkg::ESC_BYTE;
      end else begin
         ubyte = rx_byte;
      end
   end

   // Next state and result for the current byte.
   always_comb begin
      logic clear;
      clear       = 1'b0;
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      len_hi_in   = len_hi_ff;
      dlen_in     = dlen_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      crc_hi_in   = crc_hi_ff;
      cur_type_in = cur_type_ff;
      result      = '0;

      if (rx_byte == sfp_pkg::HDR_BYTE) begin
         // A header always restarts; an open frame past its type is aborted.
         if (phase_ff >= sfp_pkg::PH_LEN0 && phase_ff <= sfp_pkg::PH_CRC1) begin
            result.valid        = 1'b1;
            result.kind         = sfp_pkg::KIND_ABORT;
            result.frame_kind   = cur_type_ff;
            result.computed_crc = crc_ff;
         end
         clear = 1'b1;
      end else begin
         case (phase_ff)
            sfp_pkg::PH_HUNT: begin
               // Idle bytes are dropped.
            end
            sfp_pkg::PH_TYPE: begin
               if (rx_byte >= type_limit) begin
                  result.valid      = 1'b1;
                  result.kind       = sfp_pkg::KIND_TYPEBAD;
                  result.frame_kind = rx_byte;
                  clear             = 1'b1;
               end else begin
                  cur_type_in = rx_byte;
                  phase_in    = sfp_pkg::PH_LEN0;
               end
            end
            sfp_pkg::PH_LEN0, sfp_pkg::PH_LEN1, sfp_pkg::PH_DATA,
            sfp_pkg::PH_CRC0, sfp_pkg::PH_CRC1: begin
               if (esc_ff && rx_byte != sfp_pkg::ESC_HDR && rx_byte != sfp_pkg::ESC_ESC) begin
                  // Anything but the two escape codes after an escape byte.
                  result.valid        = 1'b1;
                  result.kind         = sfp_pkg::KIND_ESCBAD;
                  result.frame_kind   = cur_type_ff;
                  result.computed_crc = crc_ff;
                  clear               = 1'b1;
               end else if (!esc_ff && rx_byte == sfp_pkg::ESC_BYTE) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in = 1'b0;
                  case (phase_ff)
                     sfp_pkg::PH_LEN0: begin
                        len_hi_in = ubyte;
                        phase_in  = sfp_pkg::PH_LEN1;
                     end
                     sfp_pkg::PH_LEN1: begin
                        if (len_full == 16'd0 || len_full > limit) begin
                           result.valid      = 1'b1;
                           result.kind       = sfp_pkg::KIND_LENBAD;
                           result.frame_kind = cur_type_ff;
                           clear             = 1'b1;
                        end else begin
                           dlen_in   = len_full[6:0];
                           len_hi_in = len_hi_ff;
                           count_in  = 7'd0;
                           crc_in    = 16'd0;
                           phase_in  = sfp_pkg::PH_DATA;
                        end
                     end
                     sfp_pkg::PH_DATA: begin
                        result.valid        = 1'b1;
                        result.kind         = sfp_pkg::KIND_DATA;
                        result.payload_byte = ubyte;
                        result.byte_index   = count_ff[5:0];
                        result.last_byte    = is_last;
                        result.frame_kind   = cur_type_ff;
                        result.computed_crc = crc_next;
                        crc_in              = crc_next;
                        count_in            = count_next;
                        if (is_last) begin
                           phase_in = sfp_pkg::PH_CRC0;
                        end
                     end
                     sfp_pkg::PH_CRC0: begin
                        crc_hi_in = ubyte;
                        phase_in  = sfp_pkg::PH_CRC1;
                     end
                     default: begin
                        result.valid        = 1'b1;
                        result.kind         = ({crc_hi_ff, ubyte} == crc_ff)
                                              ? sfp_pkg::KIND_GOOD : sfp_pkg::KIND_CRCBAD;
                        result.frame_kind   = cur_type_ff;
                        result.computed_crc = crc_ff;
                        clear               = 1'b1;
                     end
                  endcase
               end
            end
            default: begin
               // Unused phase code: fall back to hunting.
               clear = 1'b1;
            end
         endcase
      end

      if (clear) begin
         phase_in    = (rx_byte == sfp_pkg::HDR_BYTE) ? sfp_pkg::PH_TYPE : sfp_pkg::PH_HUNT;
         esc_in      = 1'b0;
         len_hi_in   = 8'd0;
         dlen_in     = 7'd0;
         count_in    = 7'd0;
         crc_in      = 16'd0;
         crc_hi_in   = 8'd0;
         cur_type_in = 8'd0;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sfp_pkg::PH_HUNT;
         esc_ff      <= 1'b0;
         len_hi_ff   <= 8'd0;
         dlen_ff     <= 7'd0;
         count_ff    <= 7'd0;
         crc_ff      <= 16'd0;
         crc_hi_ff   <= 8'd0;
         cur_type_ff <= 8'd0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         esc_ff      <= esc_in;
         len_hi_ff   <= len_hi_in;
         dlen_ff     <= dlen_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         crc_hi_ff   <= crc_hi_in;
         cur_type_ff <= cur_type_in;
      end
   end

   // A payload byte never reaches past the declared length.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfp_pkg::PH_DATA |-> count_ff < dlen_ff)
      else $error("payload count reached declared length while still in data phase");

   // Escape pending only inside the escaped part of a frame.
   assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (phase_ff >= sfp_pkg::PH_LEN0 && phase_ff <= sfp_pkg::PH_CRC1))
      else $error("escape pending outside an escaped field");

endmodule

`default_nettype wire

/* sim/tb_stuffed_frame_parser_crc16_top.sv */
`timescale 1ns / 1ps

module tb_stuffed_frame_parser_crc16_top;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_BYTES = 400;

   // One result as the block reports it, split into its fields.
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic [5:0]  byte_index;
      logic        last_byte;
      logic [7:0]  frame_kind;
      logic [15:0] computed_crc;
   } frame_result_type;

   // Tracks the parser state for every accepted byte and holds the results still owed.
   class frame_scoreboard;
      frame_result_type expected_q[$];
      logic [7:0]    type_limit;
      logic [6:0]    max_length;
      logic [2:0]    phase;
      bit            esc_pending;
      logic [15:0]   decl_len;
      logic [6:0]    rx_count;
      logic [15:0]   crc;
      logic [7:0]    crc_hi;
      logic [7:0]    cur_type;
      int            errors;
      int            checked;
      int            kind_count[8];

      function new();
         type_limit = 8'd8;
         max_length = 7'd64;
         clear_frame();
      endfunction

      function void clear_frame();
         phase = sfp_pkg::PH_HUNT;
         esc_pending = 1'b0;
         decl_len = '0;
         rx_count = '0;
         crc = '0;
         crc_hi = '0;
         cur_type = '0;
      endfunction

      function void set_limits(input logic [7:0] tl, input logic [6:0] ml);
         type_limit = tl;
         max_length = ml;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Table-driven update: the table entry is built on the fly, MSB first.
      function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
         logic [15:0] t;
         t = {c[7:0] ^ b, 8'h00};
         repeat (8) t = t[15] ? ((t << 1) ^ sfp_pkg::CRC_POLY) : (t << 1);
         return (c >> 8) ^ t;
      endfunction

      function void add_result(input logic [2:0] kind, input logic [7:0] pb,
                               input logic [5:0] idx, input logic last,
                               input logic [7:0] fk, input logic [15:0] c);
         frame_result_type r;
         r.kind = kind;
         r.payload_byte = pb;
         r.byte_index = idx;
         r.last_byte = last;
         r.frame_kind = fk;
         r.computed_crc = c;
         expected_q.push_back(r);
      endfunction

      // Advances the parser by one received byte.
      function void note_byte(input logic [7:0] rx);
         logic [7:0]  b;
         logic [15:0] lim;
         logic        last;
         b = rx;
         // A header byte always restarts; an open frame past its type is aborted.
         if (b == sfp_pkg::HDR_BYTE) begin
            if (phase >= sfp_pkg::PH_LEN0 && phase <= sfp_pkg::PH_CRC1) begin
               add_result(sfp_pkg::KIND_ABORT, '0, '0, 1'b0, cur_type, crc);
            end
            clear_frame();
            phase = sfp_pkg::PH_TYPE;
            return;
         end
         if (phase == sfp_pkg::PH_HUNT) begin
            return;
         end
         // The type byte is taken raw.
         if (phase == sfp_pkg::PH_TYPE) begin
            if (b >= type_limit) begin
               add_result(sfp_pkg::KIND_TYPEBAD, '0, '0, 1'b0, b, '0);
               clear_frame();
            end else begin
               cur_type = b;
               phase = sfp_pkg::PH_LEN0;
            end
            return;
         end
         // Unescape length, payload and CRC bytes.
         if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == sfp_pkg::ESC_HDR) begin
               b = sfp_pkg::HDR_BYTE;
            end else if (b == sfp_pkg::ESC_ESC) begin
               b = sfp_pkg::ESC_BYTE;
            end else begin
               add_result(sfp_pkg::KIND_ESCBAD, '0, '0, 1'b0, cur_type, crc);
               clear_frame();
               return;
            end
         end else if (b == sfp_pkg::ESC_BYTE) begin
            esc_pending = 1'b1;
            return;
         end
         case (phase)
            sfp_pkg::PH_LEN0: begin
               decl_len = {b, 8'h00};
               phase = sfp_pkg::PH_LEN1;
            end
            sfp_pkg::PH_LEN1: begin
               decl_len[7:0] = b;
               lim = (16'(max_length) < sfp_pkg::MAX_PAYLOAD_W) ? 16'(max_length)
                                                               : sfp_pkg::MAX_PAYLOAD_W;
               if (decl_len == '0 || decl_len > lim) begin
                  add_result(sfp_pkg::KIND_LENBAD, '0, '0, 1'b0, cur_type, '0);
                  clear_frame();
               end else begin
                  rx_count = '0;
                  crc = '0;
                  phase = sfp_pkg::PH_DATA;
               end
            end
            sfp_pkg::PH_DATA: begin
               crc = crc_next(crc, b);
               last = (16'(rx_count) + 16'd1 == decl_len);
               add_result(sfp_pkg::KIND_DATA, b, rx_count[5:0], last, cur_type, crc);
               rx_count = rx_count + 7'd1;
               if (last) begin
                  phase = sfp_pkg::PH_CRC0;
               end
            end
            sfp_pkg::PH_CRC0: begin
               crc_hi = b;
               phase = sfp_pkg::PH_CRC1;
            end
            default: begin
               add_result(({crc_hi, b} == crc) ? sfp_pkg::KIND_GOOD : sfp_pkg::KIND_CRCBAD,
                          '0, '0, 1'b0, cur_type, crc);
               clear_frame();
            end
         endcase
      endfunction

      // Printing stops after a while so a broken block cannot flood the log.
      task report(input string msg);
         if (errors < 40) begin
            $display("MISMATCH at %0t: %s", $time, msg);
         end
         errors++;
      endtask

      task check_result(input frame_result_type got);
         frame_result_type want;
         checked++;
         kind_count[got.kind]++;
         if (expected_q.size() == 0) begin
            report($sformatf("result of kind %0d arrived with nothing expected", got.kind));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind != want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.payload_byte != want.payload_byte)
            report($sformatf("payload_byte %h, expected %h", got.payload_byte,
                             want.payload_byte));
         if (got.byte_index != want.byte_index)
            report($sformatf("byte_index %0d, expected %0d", got.byte_index,
                             want.byte_index));
         if (got.last_byte != want.last_byte)
            report($sformatf("last_byte %b, expected %b", got.last_byte, want.last_byte));
         if (got.frame_kind != want.frame_kind)
            report($sformatf("frame_kind %h, expected %h", got.frame_kind, want.frame_kind));
         if (got.computed_crc != want.computed_crc)
            report($sformatf("computed_crc %h, expected %h", got.computed_crc,
                             want.computed_crc));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = sfp_pkg::REG_TYPE_LIMIT;
   logic [7:0]  csr_wdata = '0;

   frame_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;
   int stall_cycles = 0;
   int bytes_sent = 0;

   stuffed_frame_parser_crc16_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watch both channels at each edge; a transfer on either side resets the stall count.
   initial begin
      frame_result_type got;
      bit               moved;
      forever begin
         @(posedge clock);
         moved = 1'b0;
         if (!reset && req_tvalid && req_tready) begin
            sb.note_byte(req_tdata);
            moved = 1'b1;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.payload_byte = rsp_tdata[7:0];
            got.byte_index = rsp_tdata[13:8];
            got.last_byte = rsp_tlast;
            got.frame_kind = rsp_tdata[21:14];
            got.computed_crc = rsp_tdata[37:22];
            sb.check_result(got);
            moved = 1'b1;
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_stuffed_frame_parser_crc16_top failed");
      $finish;
   end

   // Offers one byte, after a random idle gap, and waits for its transfer.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Escaped bytes go out as 0x7D followed by the byte with bit 5 flipped.
   task automatic send_esc(input logic [7:0] b);
      if (b == sfp_pkg::HDR_BYTE || b == sfp_pkg::ESC_BYTE) begin
         send_byte(sfp_pkg::ESC_BYTE);
         send_byte(b ^ 8'h20);
      end else begin
         send_byte(b);
      end
   endtask

   function automatic logic [7:0] pick_payload();
      case ($urandom_range(9))
         0: begin
            return sfp_pkg::HDR_BYTE;
         end
         1: begin
            return sfp_pkg::ESC_BYTE;
         end
         default: begin
            return 8'($urandom_range(255));
         end
      endcase
   endfunction

   function automatic logic [15:0] length_limit();
      return (sb.max_length < 7'd64) ? 16'(sb.max_length) : sfp_pkg::MAX_PAYLOAD_W;
   endfunction

   function automatic logic [15:0] pick_length();
      logic [15:0] lim;
      lim = length_limit();
      if ($urandom_range(7) == 0) begin
         return lim;
      end
      return 16'($urandom_range(1, (lim < 12) ? lim : 12));
   endfunction

   function automatic logic [7:0] good_type();
      return 8'($urandom_range(sb.type_limit - 1));
   endfunction

   // Sends header and type, then the first cut escaped units of length, payload and CRC.
   task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len, input int cut,
                             input bit corrupt);
      logic [7:0]  body[$];
      logic [15:0] c;
      logic [7:0]  d;
      c = '0;
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      for (int i = 0; i < len && i < sfp_pkg::MAX_PAYLOAD; i++) begin
         d = pick_payload();
         c = sb.crc_next(c, d);
         body.push_back(d);
      end
      if (corrupt) begin
         c = c ^ (16'h1 << $urandom_range(15));
      end
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
      send_byte(sfp_pkg::HDR_BYTE);
      send_byte(ftype);
      foreach (body[i]) begin
         if (i < cut) begin
            send_esc(body[i]);
         end
      end
   endtask

   // Malformed traffic: noise, bad type, bad length, bad escape and aborted frames.
   task automatic send_broken();
      logic [15:0] len;
      logic [7:0]  bad;
      int          n;
      len = pick_length();
      case ($urandom_range(5))
         0: begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(255)));
         end
         1: begin
            send_frame(8'($urandom_range(255, sb.type_limit)), len, 0, 1'b0);
         end
         2: begin
            case ($urandom_range(2))
               0: len = '0;
               1: len = length_limit() + 16'd1;
               default: len = 16'($urandom_range(16'hFFFF));
            endcase
            send_frame(good_type(), len, 2, 1'b0);
         end
         3: begin
            send_frame(good_type(), len, $urandom_range(len + 3), 1'b0);
            do bad = 8'($urandom_range(255));
            while (bad == sfp_pkg::ESC_HDR || bad == sfp_pkg::ESC_ESC
                   || bad == sfp_pkg::HDR_BYTE);
            send_byte(sfp_pkg::ESC_BYTE);
            send_byte(bad);
         end
         4: begin
            send_frame(good_type(), len, $urandom_range(len + 3), 1'b0);
         end
         default: begin
            // The next header lands while an escape is pending.
            send_frame(good_type(), len, $urandom_range(len + 3), 1'b0);
            send_byte(sfp_pkg::ESC_BYTE);
         end
      endcase
   endtask

   // Lets every owed result drain, then the input register and parser empty out.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] tl, input logic [6:0] ml);
      csr_we <= 1'b1;
      csr_index <= sfp_pkg::REG_TYPE_LIMIT;
      csr_wdata <= tl;
      @(posedge clock);
      csr_index <= sfp_pkg::REG_MAX_LENGTH;
      csr_wdata <= {1'b0, ml};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_limits(tl, ml);
   endtask

   // One register setting with one traffic shape; mostly well-formed frames.
   task automatic run_phase(input logic [7:0] tl, input logic [6:0] ml, input int idle_pct,
                            input int stall_pct, input bit hold_off);
      int stop_at;
      settle();
      write_regs(tl, ml);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
         if (hold_off && bytes_sent >= stop_at - PHASE_BYTES / 2) begin
            hold_cycles = HOLD_OFF_CYCLES;
            hold_off = 1'b0;
         end
         if ($urandom_range(99) < 70) begin
            send_frame(good_type(), pick_length(), 1 << 30, $urandom_range(9) == 0);
         end else begin
            send_broken();
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle bytes, double header, good and bad frames at reset settings.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(sfp_pkg::HDR_BYTE);
      send_byte(sfp_pkg::HDR_BYTE);
      send_frame(8'h00, 16'd1, 1 << 30, 1'b0);
      send_frame(8'h07, 16'd2, 1 << 30, 1'b1);
      send_frame(8'hFF, 16'd1, 0, 1'b0);
      send_frame(8'h01, 16'd0, 2, 1'b0);
      send_frame(8'h01, 16'd65, 2, 1'b0);
      send_frame(8'h02, 16'd4, 3, 1'b0);
      send_byte(sfp_pkg::ESC_BYTE);
      send_byte(8'h00);
      send_frame(8'h03, 16'd4, 4, 1'b0);
      send_byte(sfp_pkg::ESC_BYTE);
      send_frame(8'h04, 16'd3, 1 << 30, 1'b0);

      // Random: register extremes across the traffic shapes.
      run_phase(8'd255, 7'd64, 0, 0, 1'b0);
      run_phase(8'd1, 7'd1, 81, 0, 1'b0);
      run_phase(8'd100, 7'd20, 0, 81, 1'b1);
      run_phase(8'd8, 7'd64, 22, 22, 1'b1);
      run_phase(8'd130, 7'd5, 0, 0, 1'b0);

      settle();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      end
      $display("Run covered %0d received bytes in six phases, %0d results checked:",
               bytes_sent, sb.checked);
      $display("  %0d payload bytes, %0d good frames, %0d CRC errors, %0d other verdicts.",
               sb.kind_count[sfp_pkg::KIND_DATA], sb.kind_count[sfp_pkg::KIND_GOOD],
               sb.kind_count[sfp_pkg::KIND_CRCBAD],
               sb.checked - sb.kind_count[sfp_pkg::KIND_DATA]
               - sb.kind_count[sfp_pkg::KIND_GOOD] - sb.kind_count[sfp_pkg::KIND_CRCBAD]);
      if (sb.errors == 0) begin
         $display("tb_stuffed_frame_parser_crc16_top passed");
      end else begin
         $display("tb_stuffed_frame_parser_crc16_top failed");
      end
      $finish;
   end

endmodule
